// ===== sv/rsig_pkg.sv =====
`timescale 1ns / 1ps

package rsig_pkg;

  localparam int ROW_COUNT_W = 13;
  localparam int ROW_INDEX_W = 12;
  localparam int TARGET_W    = 13;
  localparam int SEED_W      = 32;
  localparam int CFG_DATA_W  = 32;
  localparam int CFG_IDX_W   = 1;
  localparam int RAND_W      = 64;
  localparam int HALF_W      = 32;
  localparam int DIV_CNT_W   = 6;

  // Epoch tag kept next to each store entry; tag zero means "never written".
  localparam int EPOCH_W = 8;

  localparam logic [TARGET_W-1:0] TARGET_RESET = 13'd4096;
  localparam logic [SEED_W-1:0]   SEED_RESET   = 32'h5356_5352;

  localparam logic [RAND_W-1:0] GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [RAND_W-1:0] MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [RAND_W-1:0] MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

  localparam int MIX_SH_A = 30;
  localparam int MIX_SH_B = 27;
  localparam int MIX_SH_C = 31;

  typedef enum logic {
    OP_START = 1'b0,
    OP_DRAW  = 1'b1
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SAMPLE_TARGET = 1'b0,
    REG_RNG_SEED      = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic load;   // reload generator from seed
    logic step;   // advance generator and reduce modulo span
  } rand_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;   // remainder valid, one-cycle pulse
  } rand_sts_t;

endpackage

// ===== sv/rsig_req_if.sv =====
`timescale 1ns / 1ps

interface rsig_req_if;
  logic                             valid;
  logic                             ready;
  logic                             operation;
  logic [rsig_pkg::ROW_COUNT_W-1:0] row_count;

  modport source (output valid, output operation, output row_count, input ready);
  modport sink   (input valid, input operation, input row_count, output ready);
endinterface

// ===== sv/rsig_rsp_if.sv =====
`timescale 1ns / 1ps

interface rsig_rsp_if;
  logic                             valid;
  logic                             ready;
  logic [rsig_pkg::ROW_INDEX_W-1:0] row_index;
  logic                             sample_valid;
  logic                             last_sample;
  logic                             exhausted;

  modport source (output valid, output row_index, output sample_valid,
                  output last_sample, output exhausted, input ready);
  modport sink   (input valid, input row_index, input sample_valid,
                  input last_sample, input exhausted, output ready);
endinterface

// ===== sv/random_sample_index_generator.sv =====
`timescale 1ns / 1ps

// Random sample index generator: draws row indices without replacement by a
// partial Fisher-Yates shuffle over a permutation store, driven by a
// SplitMix64 generator. A start transaction (operation 0) takes the row
// count, clamps the sample length to min(row_count, MAX_ROWS, sample_target),
// reloads the generator from rng_seed and logically clears the store; it
// answers with an all-zero result. Each draw transaction (operation 1)
// answers with the next sampled row, last_sample on the final one, and
// exhausted once the sample is used up. A draw runs two 64-bit multiplies,
// three partial products each on a shared 32x32 multiplier, the
// one-bit-per-cycle 64-bit remainder unit and four store accesses; an
// exhausted draw skips the generator and the store.
// Store entries carry an epoch tag, so a start normally costs nothing; after
// reset, and on every 255th start, a clearing pass over all MAX_ROWS entries
// runs, during which no transaction is accepted. Configuration writes are taken
// at any time but must only be issued while the block is idle.
module random_sample_index_generator #(
  parameter int MAX_ROWS = 4096
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [rsig_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rsig_pkg::CFG_DATA_W-1:0]    cfg_data,
  rsig_req_if.sink                           req,
  rsig_rsp_if.source                         rsp
);

  localparam int IDX_W   = $clog2(MAX_ROWS);
  localparam int CNT_W   = $clog2(MAX_ROWS + 1);
  localparam int EXT_W   = CNT_W + rsig_pkg::ROW_COUNT_W;
  localparam int WORD_W  = rsig_pkg::EPOCH_W + IDX_W;

  localparam logic [EXT_W-1:0] MAX_EXT  = EXT_W'(MAX_ROWS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_ROWS - 1);
  localparam logic [rsig_pkg::EPOCH_W-1:0] EPOCH_FIRST =
    {{(rsig_pkg::EPOCH_W - 1){1'b0}}, 1'b1};
  localparam logic [rsig_pkg::EPOCH_W-1:0] EPOCH_LAST  = '1;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_RAND  = 7'b0000010,
    S_RDJ   = 7'b0000100,
    S_WRI   = 7'b0001000,
    S_WRJ   = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_CLEAR = 7'b1000000
  } state_t;

  state_t                            state;
  logic [rsig_pkg::TARGET_W-1:0]     sample_target;
  logic [rsig_pkg::SEED_W-1:0]       rng_seed;
  logic [CNT_W-1:0]                  active_rows;
  logic [CNT_W-1:0]                  sample_len;
  logic [CNT_W-1:0]                  draw_pos;
  logic [rsig_pkg::EPOCH_W-1:0]      epoch;
  logic                              clear_pend;
  logic [IDX_W-1:0]                  clr_addr;
  logic [IDX_W-1:0]                  j_idx;
  logic [IDX_W-1:0]                  vi;
  logic [rsig_pkg::ROW_INDEX_W-1:0]  res_index;
  logic                              res_valid;
  logic                              res_last;
  logic                              res_exh;

  rsig_pkg::rand_ctl_t               rnd_ctl;
  rsig_pkg::rand_sts_t               rnd_sts;
  logic [CNT_W-1:0]                  rnd_span;
  logic [CNT_W-1:0]                  rnd_rem;

  logic                              mem_we;
  logic [IDX_W-1:0]                  mem_waddr;
  logic [WORD_W-1:0]                 mem_wdata;
  logic [IDX_W-1:0]                  mem_raddr;
  logic [WORD_W-1:0]                 mem_rdata;

  logic                              req_take;
  logic                              is_start;
  logic                              draw_ok;
  logic [EXT_W-1:0]                  rows_ext;
  logic [EXT_W-1:0]                  rows_sat;
  logic [EXT_W-1:0]                  target_ext;
  logic [EXT_W-1:0]                  len_ext;
  logic [CNT_W-1:0]                  j_full;
  logic [CNT_W-1:0]                  pos_inc;
  logic [IDX_W-1:0]                  pos_idx;
  logic [IDX_W-1:0]                  own_idx;
  logic [IDX_W-1:0]                  ent_val;
  logic [IDX_W+rsig_pkg::ROW_INDEX_W-1:0] ent_wide;
  logic                              out_free;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sample_target <= rsig_pkg::TARGET_RESET;
      rng_seed      <= rsig_pkg::SEED_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rsig_pkg::REG_SAMPLE_TARGET: sample_target <= cfg_data[rsig_pkg::TARGET_W-1:0];
        rsig_pkg::REG_RNG_SEED:      rng_seed      <= cfg_data[rsig_pkg::SEED_W-1:0];
      endcase
    end
  end

  assign req.ready = (state == S_IDLE);
  assign req_take  = req.valid && req.ready;
  assign is_start  = (req.operation == rsig_pkg::OP_START);

  assign rows_ext   = EXT_W'(req.row_count);
  assign rows_sat   = (rows_ext > MAX_EXT) ? MAX_EXT : rows_ext;
  assign target_ext = EXT_W'(sample_target);
  assign len_ext    = (target_ext < rows_sat) ? target_ext : rows_sat;

  assign draw_ok  = (draw_pos < sample_len) && (draw_pos < active_rows);
  assign pos_idx  = draw_pos[IDX_W-1:0];
  assign pos_inc  = draw_pos + 1'b1;
  assign j_full   = draw_pos + rnd_rem;
  assign rnd_span = active_rows - draw_pos;

  always_comb begin
    rnd_ctl      = '0;
    rnd_ctl.load = req_take && is_start;
    rnd_ctl.step = req_take && !is_start && draw_ok;
  end

  rsig_rand #(
    .SPAN_W (CNT_W)
  ) u_rand (
    .clk  (clk),
    .rst  (rst),
    .ctl  (rnd_ctl),
    .seed (rng_seed),
    .span (rnd_span),
    .sts  (rnd_sts),
    .rem  (rnd_rem)
  );

  // an entry not written in the current epoch reads as its own index
  assign own_idx  = (state == S_RDJ) ? pos_idx : j_idx;
  assign ent_val  = (mem_rdata[WORD_W-1:IDX_W] == epoch) ? mem_rdata[IDX_W-1:0] : own_idx;
  assign ent_wide = {{rsig_pkg::ROW_INDEX_W{1'b0}}, ent_val};

  assign mem_raddr = (state == S_RDJ) ? j_idx : pos_idx;

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_idx;
    mem_wdata = {epoch, ent_val};
    unique case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = '0;
      end
      S_WRI: begin
        mem_we = 1'b1;
      end
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_waddr = j_idx;
        mem_wdata = {epoch, vi};
      end
      default: mem_we = 1'b0;
    endcase
  end

  rsig_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAX_ROWS)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      rsp.valid   <= 1'b0;
      active_rows <= '0;
      sample_len  <= '0;
      draw_pos    <= '0;
      epoch       <= EPOCH_FIRST;
      clear_pend  <= 1'b0;
      clr_addr    <= '0;
    end else begin
      // the emit state sets valid itself when the output register frees up
      if (rsp.valid && rsp.ready && state != S_EMIT) begin
        rsp.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (req_take) begin
            res_index <= '0;
            res_valid <= 1'b0;
            res_last  <= 1'b0;
            res_exh   <= !is_start && !draw_ok;
            if (is_start) begin
              active_rows <= rows_sat[CNT_W-1:0];
              sample_len  <= len_ext[CNT_W-1:0];
              draw_pos    <= '0;
              if (epoch == EPOCH_LAST) begin
                epoch      <= EPOCH_FIRST;
                clear_pend <= 1'b1;
              end else begin
                epoch <= epoch + 1'b1;
              end
              state <= S_EMIT;
            end else if (draw_ok) begin
              state <= S_RAND;
            end else begin
              state <= S_EMIT;
            end
          end
        end
        S_RAND: begin
          // entry i is read in this cycle's address, entry j in the next
          if (rnd_sts.done) begin
            j_idx <= j_full[IDX_W-1:0];
            state <= S_RDJ;
          end
        end
        S_RDJ: begin
          vi    <= ent_val;
          state <= S_WRI;
        end
        S_WRI: begin
          res_index <= ent_wide[rsig_pkg::ROW_INDEX_W-1:0];
          state     <= S_WRJ;
        end
        S_WRJ: begin
          draw_pos  <= pos_inc;
          res_valid <= 1'b1;
          res_last  <= (pos_inc == sample_len);
          state     <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) begin
            rsp.valid        <= 1'b1;
            rsp.row_index    <= res_index;
            rsp.sample_valid <= res_valid;
            rsp.last_sample  <= res_last;
            rsp.exhausted    <= res_exh;
            state            <= clear_pend ? S_CLEAR : S_IDLE;
          end
        end
        S_CLEAR: begin
          if (clr_addr == IDX_LAST) begin
            clr_addr   <= '0;
            clear_pend <= 1'b0;
            state      <= S_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_rand_quiet_when_idle: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> !rnd_sts.busy)
    else $error("generator busy while sequencer idle");

  a_done_only_in_rand: assert property (@(posedge clk) disable iff (rst)
    rnd_sts.done |-> state == S_RAND)
    else $error("remainder done outside wait state");

  a_pos_within_length: assert property (@(posedge clk) disable iff (rst)
    draw_pos <= sample_len)
    else $error("draw position past sample length");

  a_swap_index_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_RDJ |-> CNT_W'(j_idx) < active_rows)
    else $error("swap index outside active rows");
`endif

endmodule

// ===== sv/rsig_ram.sv =====
`timescale 1ns / 1ps

module rsig_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/rsig_rand.sv =====
`timescale 1ns / 1ps

// SplitMix64 step followed by a bit-serial remainder by span.
// 64-bit multiplies run on one shared 32x32 multiplier, three partial
// products each (only the low 64 bits of the product are kept).
module rsig_rand #(
  parameter int SPAN_W = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rsig_pkg::rand_ctl_t           ctl,
  input  logic [rsig_pkg::SEED_W-1:0]   seed,
  input  logic [SPAN_W-1:0]             span,
  output rsig_pkg::rand_sts_t           sts,
  output logic [SPAN_W-1:0]             rem
);

  typedef enum logic [3:0] {
    R_IDLE = 4'b0001,
    R_MULA = 4'b0010,
    R_MULB = 4'b0100,
    R_DIV  = 4'b1000
  } rstate_t;

  localparam logic [1:0] SUB_LAST = 2'd2;
  localparam logic [rsig_pkg::DIV_CNT_W-1:0] BIT_LAST = '1;

  rstate_t                           fsm;
  logic [rsig_pkg::RAND_W-1:0]       gen_state;
  logic [rsig_pkg::RAND_W-1:0]       mx;
  logic [rsig_pkg::RAND_W-1:0]       acc;
  logic [rsig_pkg::RAND_W-1:0]       dq;
  logic [1:0]                        msub;
  logic [rsig_pkg::DIV_CNT_W-1:0]    bitcnt;
  logic [SPAN_W-1:0]                 span_q;
  logic [SPAN_W-1:0]                 rbuf;
  logic                              done;

  logic [rsig_pkg::RAND_W-1:0]       gen_next;
  logic [rsig_pkg::RAND_W-1:0]       kmul;
  logic [rsig_pkg::HALF_W-1:0]       a_op;
  logic [rsig_pkg::HALF_W-1:0]       b_op;
  logic [rsig_pkg::RAND_W-1:0]       prod;
  logic [rsig_pkg::RAND_W-1:0]       acc_next;
  logic [SPAN_W:0]                   trial;
  logic [SPAN_W:0]                   span_ext;
  logic [SPAN_W:0]                   diff;
  logic [SPAN_W-1:0]                 rbuf_next;

  assign gen_next = gen_state + rsig_pkg::GOLDEN_STEP;
  assign kmul     = (fsm == R_MULB) ? rsig_pkg::MIX_MUL_B : rsig_pkg::MIX_MUL_A;

  // lo*lo, then lo*hi and hi*lo folded into the upper half
  assign a_op = (msub == SUB_LAST) ? mx[63:32] : mx[31:0];
  assign b_op = (msub == 2'd1) ? kmul[63:32] : kmul[31:0];
  assign prod = a_op * b_op;

  always_comb begin
    if (msub == 2'd0) begin
      acc_next = prod;
    end else begin
      acc_next = {acc[63:32] + prod[31:0], acc[31:0]};
    end
  end

  assign trial     = {rbuf, dq[rsig_pkg::RAND_W-1]};
  assign span_ext  = {1'b0, span_q};
  assign diff      = trial - span_ext;
  assign rbuf_next = (trial >= span_ext) ? diff[SPAN_W-1:0] : trial[SPAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm       <= R_IDLE;
      gen_state <= {{(rsig_pkg::RAND_W - rsig_pkg::SEED_W){1'b0}}, rsig_pkg::SEED_RESET};
      done      <= 1'b0;
      msub      <= 2'd0;
      bitcnt    <= '0;
    end else begin
      done <= (fsm == R_DIV) && (bitcnt == BIT_LAST);
      unique case (fsm)
        R_IDLE: begin
          if (ctl.load) begin
            gen_state <= {{(rsig_pkg::RAND_W - rsig_pkg::SEED_W){1'b0}}, seed};
          end else if (ctl.step) begin
            gen_state <= gen_next;
            mx        <= gen_next ^ (gen_next >> rsig_pkg::MIX_SH_A);
            span_q    <= span;
            msub      <= 2'd0;
            fsm       <= R_MULA;
          end
        end
        R_MULA: begin
          acc <= acc_next;
          if (msub == SUB_LAST) begin
            mx   <= acc_next ^ (acc_next >> rsig_pkg::MIX_SH_B);
            msub <= 2'd0;
            fsm  <= R_MULB;
          end else begin
            msub <= msub + 2'd1;
          end
        end
        R_MULB: begin
          acc <= acc_next;
          if (msub == SUB_LAST) begin
            dq     <= acc_next ^ (acc_next >> rsig_pkg::MIX_SH_C);
            rbuf   <= '0;
            bitcnt <= '0;
            msub   <= 2'd0;
            fsm    <= R_DIV;
          end else begin
            msub <= msub + 2'd1;
          end
        end
        R_DIV: begin
          rbuf   <= rbuf_next;
          dq     <= dq << 1;
          bitcnt <= bitcnt + 1'b1;
          if (bitcnt == BIT_LAST) begin
            fsm <= R_IDLE;
          end
        end
        default: fsm <= R_IDLE;
      endcase
    end
  end

  assign sts.busy = (fsm != R_IDLE);
  assign sts.done = done;
  assign rem      = rbuf;

endmodule
